// ===== rtl/scs_pkg.sv =====
// Shared types and constants for the construct splitter.
// Used by the step logic and the top level.
`timescale 1ns / 1ps

package scs_pkg;

  localparam int DEPTH_BITS = 16;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] nest_depth;
    logic                  construct_started;
    logic                  in_string;
    logic                  in_comment;
    logic                  after_backslash;
    logic                  seen_nonspace;
  } split_state_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       construct_end;
    logic       unbalanced_end;
  } split_result_t;

endpackage

// ===== rtl/scs_text_if.sv =====
// Input channel: one byte of source text per item.
// Depends on nothing but the handshake convention valid/ready.
`timescale 1ns / 1ps

interface scs_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

// ===== rtl/scs_result_if.sv =====
// Output channel: one kept byte and/or construct end mark per item.
// Depends on nothing but the handshake convention valid/ready.
`timescale 1ns / 1ps

interface scs_result_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       construct_end;
  logic       unbalanced_end;

  modport source (output valid, output has_byte, output out_byte,
                  output construct_end, output unbalanced_end, input ready);
  modport sink   (input valid, input has_byte, input out_byte,
                  input construct_end, input unbalanced_end, output ready);
endinterface

// ===== rtl/scs_step.sv =====
// Combinational update of the splitter state for one text byte.
// Depends on scs_pkg for the state and result types.
`timescale 1ns / 1ps

module scs_step
  import scs_pkg::*;
(
  input  split_state_t  cur,
  input  logic [7:0]    text_byte,
  input  logic          text_last,
  output split_state_t  nxt,
  output split_result_t res,
  output logic          res_valid
);

  logic                  keep;
  logic                  balanced;
  logic                  handled;
  logic                  unbalanced;
  logic                  is_space;
  logic                  seen;
  logic [DEPTH_BITS-1:0] depth_dec;

  assign is_space  = (text_byte == CH_SPACE) ||
                     ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
  assign depth_dec = (cur.nest_depth != '0) ? cur.nest_depth - 1'b1 : cur.nest_depth;

  always_comb begin
    nxt        = cur;
    keep       = 1'b0;
    balanced   = 1'b0;
    handled    = 1'b0;
    unbalanced = 1'b0;
    seen       = cur.seen_nonspace;

    if (cur.after_backslash) begin
      nxt.after_backslash = 1'b0;
      if (text_byte == CH_QUOTE) begin
        keep    = 1'b1;
        handled = 1'b1;
      end
    end

    if (!handled) begin
      if (!cur.in_string && !cur.in_comment && text_byte == CH_OPEN) begin
        if (cur.nest_depth != '1) begin
          nxt.nest_depth = cur.nest_depth + 1'b1;
        end
        nxt.construct_started = 1'b1;
        keep = 1'b1;
      end else if (!cur.in_string && !cur.in_comment && text_byte == CH_CLOSE) begin
        nxt.nest_depth = depth_dec;
        keep = 1'b1;
        balanced = cur.construct_started && (depth_dec == '0);
      end else if (cur.in_string && text_byte == CH_BSL) begin
        keep = 1'b1;
        nxt.after_backslash = 1'b1;
      end else if (!cur.in_comment && text_byte == CH_QUOTE) begin
        nxt.in_string = !cur.in_string;
        keep = 1'b1;
      end else if (!cur.in_string && text_byte == CH_SEMI) begin
        nxt.in_comment = 1'b1;
      end else if (!cur.in_string && text_byte == CH_NL) begin
        nxt.in_comment = 1'b0;
      end else if (!cur.in_comment) begin
        keep = 1'b1;
      end
    end

    // drop leading whitespace of a construct
    if (keep && !cur.seen_nonspace && is_space) begin
      keep = 1'b0;
    end
    if (keep) begin
      seen = 1'b1;
    end
    nxt.seen_nonspace = seen;

    unbalanced = text_last && !balanced && seen;

    if (balanced || unbalanced) begin
      nxt.nest_depth        = '0;
      nxt.construct_started = 1'b0;
      nxt.seen_nonspace     = 1'b0;
    end
    if (text_last) begin
      nxt = '0;
    end

    res.has_byte       = keep;
    res.out_byte       = keep ? text_byte : 8'h00;
    res.construct_end  = balanced || unbalanced;
    res.unbalanced_end = unbalanced;
    res_valid          = keep || balanced || unbalanced;
  end

endmodule

// ===== rtl/sexpr_construct_splitter_unit.sv =====
// Construct splitter top level: input register, step logic, result register.
// A byte waits in the input register; its result is offered from the result register.
// Throughput: one byte per cycle; a stalled result register holds a byte that yields a result.
// Bytes that yield no result (dropped comments, newlines, leading spaces) emit nothing.
// Reset (rst, synchronous) clears the lexer state and both stages at once.
// Depends on scs_pkg, scs_text_if, scs_result_if and scs_step.
`timescale 1ns / 1ps

module sexpr_construct_splitter_unit
  import scs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  scs_text_if.sink     text,
  scs_result_if.source result
);

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_last;
  split_state_t  state;
  split_state_t  state_next;
  split_result_t step_res;
  logic          step_res_valid;
  logic          out_valid;
  split_result_t out_res;
  logic          out_free;
  logic          s1_advance;

  scs_step u_step (
    .cur       (state),
    .text_byte (s1_byte),
    .text_last (s1_last),
    .nxt       (state_next),
    .res       (step_res),
    .res_valid (step_res_valid)
  );

  assign out_free   = !out_valid || result.ready;
  assign s1_advance = s1_valid && (out_free || !step_res_valid);
  assign text.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
    if (text.ready && text.valid) begin
      s1_byte <= text.text_byte;
      s1_last <= text.text_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_advance && step_res_valid;
    end
    if (out_free && s1_advance && step_res_valid) begin
      out_res <= step_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.has_byte       = out_res.has_byte;
  assign result.out_byte       = out_res.out_byte;
  assign result.construct_end  = out_res.construct_end;
  assign result.unbalanced_end = out_res.unbalanced_end;

endmodule
